@@ hw/rtl/c2s_pkg.sv @@
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared constants, sideband flags and tables for the cartesian to spherical
// core: angle accumulator format, turn constants, arctangent table, gain.
// ----------------------------------------------------------------------------
package c2s_pkg;

  // coordinates are scaled up by this many guard bits inside the datapath
  localparam int unsigned GuardW = 8;

  // angle accumulator: 2^32 units per turn, headroom for start offset and residual
  localparam int unsigned AccW = 34;

  localparam logic signed [AccW-1:0] TurnHalf    = 34'sh0_8000_0000;
  localparam logic signed [AccW-1:0] TurnQuarter = 34'sh0_4000_0000;

  // inverse cordic gain in q32: limit value plus a correction for short chains
  localparam logic [31:0] InvGainLimit = 32'd2608131496;
  localparam logic [31:0] InvGainCorr  = 32'd1738754331;

  // per point flags for the exact special cases
  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic z_zero;
    logic x_neg;
    logic y_neg;
    logic z_neg;
  } c2s_flags_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] c2s_atan(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051E;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2F;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2FA;
      5'd15:   val = 32'h0000517D;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A30;
      5'd19:   val = 32'h00000518;
      5'd20:   val = 32'h0000028C;
      5'd21:   val = 32'h00000146;
      5'd22:   val = 32'h000000A3;
      5'd23:   val = 32'h00000051;
      5'd24:   val = 32'h00000029;
      5'd25:   val = 32'h00000014;
      5'd26:   val = 32'h0000000A;
      5'd27:   val = 32'h00000005;
      5'd28:   val = 32'h00000003;
      5'd29:   val = 32'h00000001;
      5'd30:   val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

  // inverse gain for a chain of the given length, rounded to q32
  function automatic logic [31:0] c2s_inv_gain(input int unsigned stages);
    logic [63:0]  g;
    int unsigned  s;
    g = 64'(InvGainLimit);
    s = 2 * stages;
    if (stages >= 1 && stages < 16) begin
      g = g + ((64'(InvGainCorr) + (64'd1 << (s - 1))) >> s);
    end
    return g[31:0];
  endfunction

endpackage

@@ hw/rtl/c2s_cordic.sv @@
// ----------------------------------------------------------------------------
// c2s_cordic
// Pipelined vectoring cordic: one micro-rotation per register stage, drives
// y toward zero and accumulates the angle. Sideband bits ride along.
// ----------------------------------------------------------------------------
module c2s_cordic #(
  parameter int unsigned DataW  = 36,
  parameter int unsigned Stages = 20,
  parameter int unsigned SideW  = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [DataW-1:0]           x_i,
  input  logic signed [DataW-1:0]           y_i,
  input  logic signed [c2s_pkg::AccW-1:0]   ang_i,
  input  logic        [SideW-1:0]           side_i,
  output logic                              valid_o,
  output logic signed [DataW-1:0]           x_o,
  output logic signed [DataW-1:0]           y_o,
  output logic signed [c2s_pkg::AccW-1:0]   ang_o,
  output logic        [SideW-1:0]           side_o
);
  import c2s_pkg::*;

  logic                    vld_q  [Stages];
  logic signed [DataW-1:0] x_q    [Stages];
  logic signed [DataW-1:0] y_q    [Stages];
  logic signed [AccW-1:0]  ang_q  [Stages];
  logic        [SideW-1:0] side_q [Stages];

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    localparam logic signed [AccW-1:0] Step = AccW'(c2s_atan(5'(i)));

    logic                    v_in;
    logic signed [DataW-1:0] x_in;
    logic signed [DataW-1:0] y_in;
    logic signed [AccW-1:0]  a_in;
    logic        [SideW-1:0] s_in;
    logic signed [DataW-1:0] x_d;
    logic signed [DataW-1:0] y_d;
    logic signed [AccW-1:0]  a_d;

    // stage input: module port for the first stage, previous stage otherwise
    if (i == 0) begin : g_first
      assign v_in = valid_i;
      assign x_in = x_i;
      assign y_in = y_i;
      assign a_in = ang_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = vld_q[i-1];
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign a_in = ang_q[i-1];
      assign s_in = side_q[i-1];
    end

    // micro-rotation, direction from the sign of y
    always_comb begin
      if (!y_in[DataW-1]) begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        a_d = a_in + Step;
      end else begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        a_d = a_in - Step;
      end
    end

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= v_in;
      end
    end

    // stage payload
    always_ff @(posedge clk_i) begin
      if (v_in) begin
        x_q[i]    <= x_d;
        y_q[i]    <= y_d;
        ang_q[i]  <= a_d;
        side_q[i] <= s_in;
      end
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign x_o     = x_q[Stages-1];
  assign y_o     = y_q[Stages-1];
  assign ang_o   = ang_q[Stages-1];
  assign side_o  = side_q[Stages-1];

endmodule

@@ hw/rtl/c2s_gain.sv @@
// ----------------------------------------------------------------------------
// c2s_gain
// Two-stage gain correction: multiplies a non-negative value by the inverse
// cordic gain in q32 and rounds half up. Angle and sideband ride along.
// ----------------------------------------------------------------------------
module c2s_gain #(
  parameter int unsigned DataW  = 36,
  parameter int unsigned Stages = 20,
  parameter int unsigned SideW  = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [DataW-1:0]           v_i,
  input  logic signed [c2s_pkg::AccW-1:0]   ang_i,
  input  logic        [SideW-1:0]           side_i,
  output logic                              valid_o,
  output logic signed [DataW-1:0]           v_o,
  output logic signed [c2s_pkg::AccW-1:0]   ang_o,
  output logic        [SideW-1:0]           side_o
);
  import c2s_pkg::*;

  localparam logic [31:0] Gain    = c2s_inv_gain(Stages);
  localparam int unsigned HiW     = (DataW > 32) ? DataW - 32 : 1;
  localparam int unsigned ExtW    = DataW + 31;
  localparam int unsigned ProdHiW = HiW + 32;
  localparam int unsigned SumW    = HiW + 34;

  logic [DataW-2:0]   mag;
  logic [ExtW-1:0]    ext;
  logic [63:0]        p_lo_d;
  logic [ProdHiW-1:0] p_hi_d;
  logic [64:0]        rnd;
  logic [SumW-1:0]    sum;

  logic                    vld_a_q;
  logic [63:0]             p_lo_q;
  logic [ProdHiW-1:0]      p_hi_q;
  logic signed [AccW-1:0]  ang_a_q;
  logic [SideW-1:0]        side_a_q;
  logic                    vld_b_q;
  logic signed [DataW-1:0] v_q;
  logic signed [AccW-1:0]  ang_b_q;
  logic [SideW-1:0]        side_b_q;

  // partial products: low 32 bits and the few bits above them
  always_comb begin
    mag    = v_i[DataW-1] ? '0 : v_i[DataW-2:0];
    ext    = ExtW'(mag);
    p_lo_d = 64'(ext[31:0]) * 64'(Gain);
    p_hi_d = ProdHiW'(ext[32 +: HiW]) * ProdHiW'(Gain);
  end

  // recombine with rounding of the low product
  always_comb begin
    rnd = 65'(p_lo_q) + 65'h0_8000_0000;
    sum = SumW'(p_hi_q) + SumW'(rnd[64:32]);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
    end
  end

  // product stage
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      p_lo_q   <= p_lo_d;
      p_hi_q   <= p_hi_d;
      ang_a_q  <= ang_i;
      side_a_q <= side_i;
    end
  end

  // sum stage
  always_ff @(posedge clk_i) begin
    if (vld_a_q) begin
      v_q      <= $signed(sum[DataW-1:0]);
      ang_b_q  <= ang_a_q;
      side_b_q <= side_a_q;
    end
  end

  assign valid_o = vld_b_q;
  assign v_o     = v_q;
  assign ang_o   = ang_b_q;
  assign side_o  = side_b_q;

endmodule

@@ hw/rtl/c2s_format.sv @@
// ----------------------------------------------------------------------------
// c2s_format
// Output formatting in two stages: exact special-case angles, clamping and
// radius rounding, then angle rounding to the output unit and radius saturation.
// ----------------------------------------------------------------------------
module c2s_format #(
  parameter int unsigned CoordW = 24,
  parameter int unsigned AngleW = 18,
  parameter int unsigned DataW  = 36
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [DataW-1:0]           r_i,
  input  logic signed [c2s_pkg::AccW-1:0]   pol_i,
  input  logic signed [c2s_pkg::AccW-1:0]   az_i,
  input  c2s_pkg::c2s_flags_t               flags_i,
  output logic                              valid_o,
  output logic        [CoordW-1:0]          radius_o,
  output logic        [AngleW-1:0]          polar_angle_o,
  output logic signed [AngleW:0]            azimuth_o
);
  import c2s_pkg::*;

  localparam int unsigned RadW = DataW - GuardW;
  localparam int unsigned Sh   = 32 - AngleW;

  logic [DataW-2:0]       mag;
  logic [DataW-1:0]       rsum;
  logic signed [AccW-1:0] az_d;
  logic signed [AccW-1:0] pol_d;
  logic signed [AccW-1:0] az_rnd;
  logic signed [AccW-1:0] pol_rnd;
  logic [CoordW-1:0]      radius_d;

  logic                   vld1_q;
  logic signed [AccW-1:0] az_q;
  logic signed [AccW-1:0] pol_q;
  logic [RadW-1:0]        rad_q;
  logic                   vld2_q;
  logic [CoordW-1:0]      radius_q;
  logic [AngleW-1:0]      polar_q;
  logic signed [AngleW:0] azim_q;

  // azimuth: exact values on the axes, otherwise clamp to half a turn
  always_comb begin
    az_d = az_i;
    if (flags_i.x_zero && flags_i.y_zero) begin
      az_d = '0;
    end else if (flags_i.x_zero) begin
      az_d = flags_i.y_neg ? -TurnQuarter : TurnQuarter;
    end else if (flags_i.y_zero) begin
      az_d = flags_i.x_neg ? TurnHalf : '0;
    end else if (az_i > TurnHalf) begin
      az_d = TurnHalf;
    end else if (az_i < -TurnHalf) begin
      az_d = -TurnHalf;
    end
  end

  // polar angle: origin, xy plane and z axis exact, otherwise clamp
  always_comb begin
    pol_d = pol_i;
    if (flags_i.x_zero && flags_i.y_zero && flags_i.z_zero) begin
      pol_d = '0;
    end else if (flags_i.z_zero) begin
      pol_d = TurnQuarter;
    end else if (flags_i.x_zero && flags_i.y_zero) begin
      pol_d = flags_i.z_neg ? TurnHalf : '0;
    end else if (pol_i > TurnHalf) begin
      pol_d = TurnHalf;
    end else if (pol_i < 0) begin
      pol_d = '0;
    end
  end

  // radius: drop guard bits with half-up rounding
  always_comb begin
    mag  = r_i[DataW-1] ? '0 : r_i[DataW-2:0];
    rsum = DataW'(mag) + DataW'(1 << (GuardW - 1));
  end

  // angle rounding to the output unit
  if (Sh > 0) begin : g_round
    localparam logic signed [AccW-1:0] Half = AccW'(1) << (Sh - 1);
    assign pol_rnd = (pol_q + Half) >>> Sh;
    assign az_rnd  = (az_q + Half) >>> Sh;
  end else begin : g_exact
    assign pol_rnd = pol_q;
    assign az_rnd  = az_q;
  end

  // radius saturation to the coordinate range
  assign radius_d = (|rad_q[RadW-1:CoordW]) ? '1 : rad_q[CoordW-1:0];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  // select stage
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      az_q  <= az_d;
      pol_q <= pol_d;
      rad_q <= rsum[DataW-1:GuardW];
    end
  end

  // output registers
  always_ff @(posedge clk_i) begin
    if (vld1_q) begin
      radius_q <= radius_d;
      polar_q  <= pol_rnd[AngleW-1:0];
      azim_q   <= az_rnd[AngleW:0];
    end
  end

  assign valid_o       = vld2_q;
  assign radius_o      = radius_q;
  assign polar_angle_o = polar_q;
  assign azimuth_o     = azim_q;

endmodule

@@ hw/rtl/cartesian_to_spherical_core.sv @@
// ----------------------------------------------------------------------------
// cartesian_to_spherical_core
// Cartesian point to radius, polar angle and azimuth by two cascaded
// pipelined vectoring cordics with gain correction between them.
//
//   channel  | handshake       | payload
//   ---------+-----------------+------------------------------------------
//   point    | start / busy    | coord_x_i, coord_y_i, coord_z_i
//   result   | done_o (strobe) | radius_o, polar_angle_o, azimuth_o
//
// one point is taken every cycle; each result passes in turn the entry stage,
// the xy cordic chain and its gain multiplier, the middle stage, the rz cordic
// chain and its gain multiplier and two format stages, with one iteration per
// cordic register stage and two stages in each gain multiplier.
// reset clears the valid bits only; the pipeline then is empty.
// busy stays low: nothing ever stalls, and done_o is high for one cycle.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_core #(
  parameter int unsigned COORD_BITS    = 24,
  parameter int unsigned ANGLE_BITS    = 18,
  parameter int unsigned CORDIC_STAGES = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  input  logic signed [COORD_BITS-1:0] coord_z_i,
  output logic                         done_o,
  output logic        [COORD_BITS-1:0] radius_o,
  output logic        [ANGLE_BITS-1:0] polar_angle_o,
  output logic signed [ANGLE_BITS:0]   azimuth_o
);
  import c2s_pkg::*;

  localparam int unsigned DataW   = COORD_BITS + GuardW + 4;
  localparam int unsigned Latency = 2 * CORDIC_STAGES + 8;

  typedef struct packed {
    c2s_flags_t                  flags;
    logic signed [COORD_BITS-1:0] z;
  } side1_t;

  typedef struct packed {
    c2s_flags_t             flags;
    logic signed [AccW-1:0] az;
  } side2_t;

  localparam int unsigned Side1W = $bits(side1_t);
  localparam int unsigned Side2W = $bits(side2_t);

  logic signed [DataW-1:0] ax;
  logic signed [DataW-1:0] ay;
  logic signed [DataW-1:0] bz;
  logic signed [DataW-1:0] ent_x_d;
  logic signed [DataW-1:0] ent_y_d;
  logic signed [AccW-1:0]  ent_a_d;
  side1_t                  ent_side_d;
  logic signed [DataW-1:0] mid_x_d;
  logic signed [DataW-1:0] mid_y_d;
  logic signed [AccW-1:0]  mid_a_d;
  side2_t                  mid_side_d;

  logic                    ent_vld_q;
  logic signed [DataW-1:0] ent_x_q;
  logic signed [DataW-1:0] ent_y_q;
  logic signed [AccW-1:0]  ent_a_q;
  side1_t                  ent_side_q;
  logic                    mid_vld_q;
  logic signed [DataW-1:0] mid_x_q;
  logic signed [DataW-1:0] mid_y_q;
  logic signed [AccW-1:0]  mid_a_q;
  side2_t                  mid_side_q;

  logic                    c1_vld;
  logic signed [DataW-1:0] c1_x;
  logic signed [DataW-1:0] c1_y;
  logic signed [AccW-1:0]  c1_ang;
  side1_t                  c1_side;
  logic                    g1_vld;
  logic signed [DataW-1:0] g1_v;
  logic signed [AccW-1:0]  g1_ang;
  side1_t                  g1_side;
  logic                    c2_vld;
  logic signed [DataW-1:0] c2_x;
  logic signed [DataW-1:0] c2_y;
  logic signed [AccW-1:0]  c2_ang;
  side2_t                  c2_side;
  logic                    g2_vld;
  logic signed [DataW-1:0] g2_v;
  logic signed [AccW-1:0]  g2_ang;
  side2_t                  g2_side;

  // the pipeline takes a beat every cycle
  assign busy = 1'b0;

  // entry: scale up, fold the left half plane onto the right
  always_comb begin
    ax = DataW'(coord_x_i) <<< GuardW;
    ay = DataW'(coord_y_i) <<< GuardW;
    ent_side_d.flags.x_zero = (coord_x_i == '0);
    ent_side_d.flags.y_zero = (coord_y_i == '0);
    ent_side_d.flags.z_zero = (coord_z_i == '0);
    ent_side_d.flags.x_neg  = coord_x_i[COORD_BITS-1];
    ent_side_d.flags.y_neg  = coord_y_i[COORD_BITS-1];
    ent_side_d.flags.z_neg  = coord_z_i[COORD_BITS-1];
    ent_side_d.z            = coord_z_i;
    if (coord_x_i[COORD_BITS-1]) begin
      ent_x_d = -ax;
      ent_y_d = -ay;
      ent_a_d = coord_y_i[COORD_BITS-1] ? -TurnHalf : TurnHalf;
    end else begin
      ent_x_d = ax;
      ent_y_d = ay;
      ent_a_d = '0;
    end
  end

  // between the cordics: (z, xy radius), rotated a quarter turn for z below zero
  always_comb begin
    bz               = DataW'(g1_side.z) <<< GuardW;
    mid_side_d.flags = g1_side.flags;
    mid_side_d.az    = g1_ang;
    if (g1_side.flags.z_neg) begin
      mid_x_d = g1_v;
      mid_y_d = -bz;
      mid_a_d = TurnQuarter;
    end else begin
      mid_x_d = bz;
      mid_y_d = g1_v;
      mid_a_d = '0;
    end
  end

  // valid bits of the entry and middle stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
      mid_vld_q <= 1'b0;
    end else begin
      ent_vld_q <= start && !busy;
      mid_vld_q <= g1_vld;
    end
  end

  // entry stage payload
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      ent_x_q    <= ent_x_d;
      ent_y_q    <= ent_y_d;
      ent_a_q    <= ent_a_d;
      ent_side_q <= ent_side_d;
    end
  end

  // middle stage payload
  always_ff @(posedge clk_i) begin
    if (g1_vld) begin
      mid_x_q    <= mid_x_d;
      mid_y_q    <= mid_y_d;
      mid_a_q    <= mid_a_d;
      mid_side_q <= mid_side_d;
    end
  end

  // xy plane: azimuth and xy radius
  c2s_cordic #(
    .DataW  (DataW),
    .Stages (CORDIC_STAGES),
    .SideW  (Side1W)
  ) u_cordic_xy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ent_vld_q),
    .x_i     (ent_x_q),
    .y_i     (ent_y_q),
    .ang_i   (ent_a_q),
    .side_i  (ent_side_q),
    .valid_o (c1_vld),
    .x_o     (c1_x),
    .y_o     (c1_y),
    .ang_o   (c1_ang),
    .side_o  (c1_side)
  );

  c2s_gain #(
    .DataW  (DataW),
    .Stages (CORDIC_STAGES),
    .SideW  (Side1W)
  ) u_gain_xy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c1_vld),
    .v_i     (c1_x),
    .ang_i   (c1_ang),
    .side_i  (c1_side),
    .valid_o (g1_vld),
    .v_o     (g1_v),
    .ang_o   (g1_ang),
    .side_o  (g1_side)
  );

  // (z, xy radius): polar angle and full radius
  c2s_cordic #(
    .DataW  (DataW),
    .Stages (CORDIC_STAGES),
    .SideW  (Side2W)
  ) u_cordic_rz (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_vld_q),
    .x_i     (mid_x_q),
    .y_i     (mid_y_q),
    .ang_i   (mid_a_q),
    .side_i  (mid_side_q),
    .valid_o (c2_vld),
    .x_o     (c2_x),
    .y_o     (c2_y),
    .ang_o   (c2_ang),
    .side_o  (c2_side)
  );

  c2s_gain #(
    .DataW  (DataW),
    .Stages (CORDIC_STAGES),
    .SideW  (Side2W)
  ) u_gain_rz (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c2_vld),
    .v_i     (c2_x),
    .ang_i   (c2_ang),
    .side_i  (c2_side),
    .valid_o (g2_vld),
    .v_o     (g2_v),
    .ang_o   (g2_ang),
    .side_o  (g2_side)
  );

  c2s_format #(
    .CoordW (COORD_BITS),
    .AngleW (ANGLE_BITS),
    .DataW  (DataW)
  ) u_format (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (g2_vld),
    .r_i           (g2_v),
    .pol_i         (g2_ang),
    .az_i          (g2_side.az),
    .flags_i       (g2_side.flags),
    .valid_o       (done_o),
    .radius_o      (radius_o),
    .polar_angle_o (polar_angle_o),
    .azimuth_o     (azimuth_o)
  );

  // residual y of the vectoring chains is not part of the result
  logic unused_resid;
  assign unused_resid = ^{c1_y, c2_y};

  // ----------------------------------------------------------------------------
  // assertions
  // ----------------------------------------------------------------------------
  localparam logic        [ANGLE_BITS-1:0] PolHalf = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic signed [ANGLE_BITS:0]   AzHalf  = (ANGLE_BITS + 1)'(1) << (ANGLE_BITS - 1);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##Latency done_o)
    else $error("result strobe missing after accepted beat");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |-> ##Latency !done_o)
    else $error("result strobe without accepted beat");

  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && coord_x_i == '0 && coord_y_i == '0 && coord_z_i == '0) |-> ##Latency
    (radius_o == '0 && polar_angle_o == '0 && azimuth_o == '0))
    else $error("origin does not map to all zero");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (polar_angle_o <= PolHalf && azimuth_o <= AzHalf && azimuth_o >= -AzHalf))
    else $error("angle out of range");

endmodule
